@@ design/fbse_pkg.sv @@
// Shared constants, codes and the command type of the frame buffer span engine.
package fbse_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 128;

    localparam int ROW_BYTES   = (SCREEN_WIDTH + 1) / 2;
    localparam int STORE_DEPTH = SCREEN_HEIGHT * ROW_BYTES;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int MAX_DIM     = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int COORD_W     = $clog2(MAX_DIM);

    // signed working width for clipping math
    localparam int CALC_W = 11;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [2:0] OP_POINT = 3'd0;
    localparam logic [2:0] OP_HFG   = 3'd1;
    localparam logic [2:0] OP_HBG   = 3'd2;
    localparam logic [2:0] OP_HINV  = 3'd3;
    localparam logic [2:0] OP_VFG   = 3'd4;
    localparam logic [2:0] OP_VINV  = 3'd5;
    localparam logic [2:0] OP_READ  = 3'd6;

    localparam logic [PADDR_W-3:0] REG_FG     = (PADDR_W-2)'(0);
    localparam logic [PADDR_W-3:0] REG_BG     = (PADDR_W-2)'(1);
    localparam logic [PADDR_W-3:0] REG_LEFT   = (PADDR_W-2)'(2);
    localparam logic [PADDR_W-3:0] REG_RIGHT  = (PADDR_W-2)'(3);
    localparam logic [PADDR_W-3:0] REG_TOP    = (PADDR_W-2)'(4);
    localparam logic [PADDR_W-3:0] REG_BOTTOM = (PADDR_W-2)'(5);

    // Resolved command: clipping done, ranges on screen and non-empty.
    // Horizontal: fixed = row, first/last = x. Vertical and read: fixed = x,
    // first/last = row.
    typedef struct packed {
        logic               is_read;
        logic               on_screen;
        logic               vertical;
        logic               invert;
        logic [3:0]         color;
        logic [COORD_W-1:0] fixed;
        logic [COORD_W-1:0] first;
        logic [COORD_W-1:0] last;
    } fbse_cmd_t;

endpackage

@@ design/fbse_front.sv @@
// Front end: configuration registers, command intake, clipping and classification.
module fbse_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fbse_pkg::PADDR_W-1:0]  paddr,
    input  logic [fbse_pkg::PDATA_W-1:0]  pwdata,
    output logic [fbse_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  logic [2:0]                    operation,
    input  logic signed [8:0]             pos_x,
    input  logic signed [8:0]             pos_y,
    input  logic signed [8:0]             span_start,
    input  logic signed [8:0]             span_end,
    input  logic                          queue_full,
    input  logic                          clearing,
    output logic                          push,
    output fbse_pkg::fbse_cmd_t           push_cmd
);
    import fbse_pkg::*;

    logic [3:0] fg_reg;
    logic [3:0] bg_reg;
    logic [6:0] left_reg;
    logic [6:0] right_reg;
    logic [7:0] top_reg;
    logic [7:0] bottom_reg;

    logic                   wr_en;
    logic [PADDR_W-3:0]     reg_sel;

    logic signed [CALC_W-1:0] px_s, py_s, s0_s, s1_s;
    logic signed [CALC_W-1:0] cl_s, cr_s, ct_s, cb_s, cb_m1;
    logic signed [CALC_W-1:0] w_m1, h_m1;
    logic signed [CALC_W-1:0] h_a, h_b, h_lo, h_hi0, h_hi;
    logic signed [CALC_W-1:0] v_lo, v_hi0, v_hi;
    logic                     row_ok, col_ok, h_go, v_go, rd_on, go;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg     <= 4'd15;
            bg_reg     <= 4'd0;
            left_reg   <= 7'd0;
            right_reg  <= 7'd127;
            top_reg    <= 8'd0;
            bottom_reg <= 8'd128;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_FG:     fg_reg     <= pwdata[3:0];
                REG_BG:     bg_reg     <= pwdata[3:0];
                REG_LEFT:   left_reg   <= pwdata[6:0];
                REG_RIGHT:  right_reg  <= pwdata[6:0];
                REG_TOP:    top_reg    <= pwdata[7:0];
                REG_BOTTOM: bottom_reg <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_FG:     prdata = PDATA_W'(fg_reg);
            REG_BG:     prdata = PDATA_W'(bg_reg);
            REG_LEFT:   prdata = PDATA_W'(left_reg);
            REG_RIGHT:  prdata = PDATA_W'(right_reg);
            REG_TOP:    prdata = PDATA_W'(top_reg);
            REG_BOTTOM: prdata = PDATA_W'(bottom_reg);
            default:    prdata = '0;
        endcase
    end

    // sign-extend everything into one signed width
    assign px_s  = CALC_W'(pos_x);
    assign py_s  = CALC_W'(pos_y);
    assign s0_s  = CALC_W'(span_start);
    assign s1_s  = CALC_W'(span_end);
    assign cl_s  = CALC_W'($signed({1'b0, left_reg}));
    assign cr_s  = CALC_W'($signed({1'b0, right_reg}));
    assign ct_s  = CALC_W'($signed({1'b0, top_reg}));
    assign cb_s  = CALC_W'($signed({1'b0, bottom_reg}));
    assign cb_m1 = cb_s - CALC_W'(1);
    assign w_m1  = CALC_W'(SCREEN_WIDTH - 1);
    assign h_m1  = CALC_W'(SCREEN_HEIGHT - 1);

    // horizontal span (a point is a one-pixel span)
    assign h_a    = (operation == OP_POINT) ? px_s : s0_s;
    assign h_b    = (operation == OP_POINT) ? px_s : s1_s;
    assign h_lo   = (h_a > cl_s) ? h_a : cl_s;
    assign h_hi0  = (h_b < cr_s) ? h_b : cr_s;
    assign h_hi   = (h_hi0 < w_m1) ? h_hi0 : w_m1;
    assign row_ok = (py_s >= ct_s) && (py_s < cb_s) && !py_s[CALC_W-1] && (py_s <= h_m1);
    assign h_go   = row_ok && (h_lo <= h_hi);

    // vertical span
    assign v_lo   = (s0_s > ct_s) ? s0_s : ct_s;
    assign v_hi0  = (s1_s < cb_m1) ? s1_s : cb_m1;
    assign v_hi   = (v_hi0 < h_m1) ? v_hi0 : h_m1;
    assign col_ok = (px_s >= cl_s) && (px_s <= cr_s) && (px_s <= w_m1);
    assign v_go   = col_ok && (v_lo <= v_hi);

    assign rd_on = !px_s[CALC_W-1] && (px_s <= w_m1) && !py_s[CALC_W-1] && (py_s <= h_m1);

    always_comb
    begin
        push_cmd = '0;
        go       = 1'b0;
        unique case (operation)
            OP_POINT, OP_HFG, OP_HBG, OP_HINV:
            begin
                push_cmd.fixed  = COORD_W'(py_s);
                push_cmd.first  = COORD_W'(h_lo);
                push_cmd.last   = COORD_W'(h_hi);
                push_cmd.color  = (operation == OP_HBG) ? bg_reg : fg_reg;
                push_cmd.invert = (operation == OP_HINV);
                go              = h_go;
            end
            OP_VFG, OP_VINV:
            begin
                push_cmd.vertical = 1'b1;
                push_cmd.fixed    = COORD_W'(px_s);
                push_cmd.first    = COORD_W'(v_lo);
                push_cmd.last     = COORD_W'(v_hi);
                push_cmd.color    = fg_reg;
                push_cmd.invert   = (operation == OP_VINV);
                go                = v_go;
            end
            OP_READ:
            begin
                push_cmd.is_read   = 1'b1;
                push_cmd.on_screen = rd_on;
                push_cmd.vertical  = 1'b1;
                push_cmd.fixed     = rd_on ? COORD_W'(px_s) : '0;
                push_cmd.first     = rd_on ? COORD_W'(py_s) : '0;
                push_cmd.last      = rd_on ? COORD_W'(py_s) : '0;
                go                 = 1'b1;
            end
            default: go = 1'b0;
        endcase
    end

    assign cmd_stall = queue_full | clearing;
    assign push      = cmd_valid & ~cmd_stall & go;

endmodule

@@ design/fbse_queue.sv @@
// Short command queue between the front end and the store sequencer.
module fbse_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  fbse_pkg::fbse_cmd_t  push_cmd,
    input  logic                 pop,
    output logic                 full,
    output logic                 head_valid,
    output fbse_pkg::fbse_cmd_t  head
);
    import fbse_pkg::*;

    fbse_cmd_t          slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_cmd;
    end

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slots[rd_ptr_reg];

endmodule

@@ design/fbse_back.sv @@
// Back end: frame store, clearing pass and the byte read-modify-write sequencer.
module fbse_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  fbse_pkg::fbse_cmd_t  head,
    output logic                 pop,
    output logic                 clearing,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic [3:0]           pixel_value
);
    import fbse_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    logic [7:0] store [STORE_DEPTH];

    logic [1:0]         state_reg, state_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    fbse_cmd_t          cmd_reg, cmd_next;
    logic [COORD_W-1:0] cur_reg, cur_next;

    logic               pend_valid_reg, pend_read_reg, pend_on_reg;
    logic               pend_hi_en_reg, pend_lo_en_reg, pend_sel_lo_reg;
    logic               pend_invert_reg;
    logic [3:0]         pend_color_reg;
    logic [ADDR_W-1:0]  pend_addr_reg;
    logic [7:0]         rd_data_reg;

    logic               out_valid_reg, out_valid_next;
    logic [3:0]         out_data_reg;

    logic               start, running, last_step;
    logic [COORD_W-1:0] end_idx, first_byte, last_byte, row, byte_idx;
    logic [ADDR_W-1:0]  rd_addr;
    logic               hi_en, lo_en;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [7:0]         mem_wdata;
    logic [3:0]         old_hi, old_lo, new_hi, new_lo;

    assign running    = (state_reg == ST_RUN);
    assign clearing   = (state_reg == ST_CLEAR);
    assign first_byte = cmd_reg.first >> 1;
    assign last_byte  = cmd_reg.last >> 1;
    assign end_idx    = cmd_reg.vertical ? cmd_reg.last : last_byte;
    assign last_step  = (cur_reg == end_idx);

    // a read waits until the result register and the pipe hold no earlier result
    assign start = (state_reg == ST_IDLE) && head_valid &&
                   (!head.is_read || (!out_valid_reg && !(pend_valid_reg && pend_read_reg)));
    assign pop   = start;

    assign row      = cmd_reg.vertical ? cur_reg : cmd_reg.fixed;
    assign byte_idx = cmd_reg.vertical ? (cmd_reg.fixed >> 1) : cur_reg;
    assign rd_addr  = ADDR_W'(row) * ADDR_W'(ROW_BYTES) + ADDR_W'(byte_idx);

    always_comb
    begin
        if (cmd_reg.is_read)
        begin
            hi_en = 1'b0;
            lo_en = 1'b0;
        end
        else if (cmd_reg.vertical)
        begin
            hi_en = !cmd_reg.fixed[0];
            lo_en = cmd_reg.fixed[0];
        end
        else
        begin
            // partial bytes at an odd start or an even end
            hi_en = !((cur_reg == first_byte) && cmd_reg.first[0]);
            lo_en = !((cur_reg == last_byte) && !cmd_reg.last[0]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cmd_next   = cmd_reg;
        cur_next   = cur_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(STORE_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = head;
                    cur_next   = head.vertical ? head.first : (head.first >> 1);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_step)
                    state_next = ST_IDLE;
                else
                    cur_next = cur_reg + COORD_W'(1);
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            pend_valid_reg <= running;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        cur_reg <= cur_next;
        if (running)
        begin
            pend_read_reg   <= cmd_reg.is_read;
            pend_on_reg     <= cmd_reg.on_screen;
            pend_hi_en_reg  <= hi_en;
            pend_lo_en_reg  <= lo_en;
            pend_sel_lo_reg <= cmd_reg.fixed[0];
            pend_invert_reg <= cmd_reg.invert;
            pend_color_reg  <= cmd_reg.color;
            pend_addr_reg   <= rd_addr;
        end
    end

    // store read port
    always_ff @(posedge clk)
    begin
        if (running)
            rd_data_reg <= store[rd_addr];
    end

    assign old_hi = rd_data_reg[7:4];
    assign old_lo = rd_data_reg[3:0];
    assign new_hi = pend_hi_en_reg ? (pend_invert_reg ? ~old_hi : pend_color_reg) : old_hi;
    assign new_lo = pend_lo_en_reg ? (pend_invert_reg ? ~old_lo : pend_color_reg) : old_lo;

    assign mem_we    = clearing || (pend_valid_reg && !pend_read_reg);
    assign mem_waddr = clearing ? clr_reg : pend_addr_reg;
    assign mem_wdata = clearing ? 8'h00 : {new_hi, new_lo};

    // store write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store[mem_waddr] <= mem_wdata;
    end

    always_comb
    begin
        if (pend_valid_reg && pend_read_reg)
            out_valid_next = 1'b1;
        else if (!rsp_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pend_valid_reg && pend_read_reg)
            out_data_reg <= pend_on_reg ? (pend_sel_lo_reg ? old_lo : old_hi) : 4'd0;
    end

    assign rsp_valid   = out_valid_reg;
    assign pixel_value = out_data_reg;

endmodule

@@ design/nibble_framebuffer_span_engine.sv @@
// Top level of the packed 4-bit frame buffer span engine.
//
//   channel   direction  handshake             payload
//   apb       in/out     psel/penable/pready   paddr, pwdata, prdata (6 registers)
//   cmd       in         cmd_valid/cmd_stall   operation, pos_x, pos_y, span_start, span_end
//   rsp       out        rsp_valid/rsp_stall   pixel_value (one item per read command)
//
// Sequencing: a horizontal span steps through the bytes it touches, a vertical
// span through its rows, a point or a read through a single byte; the store
// does one byte read-modify-write per cycle while a command runs, through its
// registered read port and its write port.
// Reset: a clearing pass writes zero to all STORE_DEPTH (8192) bytes, one per
// cycle; cmd_stall stays high throughout. Configuration writes are taken as ever.
// Stalls: a two-entry command queue separates intake from the store sequencer.
// A held result stops the next read and what queues behind it; earlier drawing runs on.
module nibble_framebuffer_span_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fbse_pkg::PADDR_W-1:0]  paddr,
    input  logic [fbse_pkg::PDATA_W-1:0]  pwdata,
    output logic [fbse_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    // command items
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  logic [2:0]                    operation,
    input  logic signed [8:0]             pos_x,
    input  logic signed [8:0]             pos_y,
    input  logic signed [8:0]             span_start,
    input  logic signed [8:0]             span_end,
    // read results
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [3:0]                    pixel_value
);
    import fbse_pkg::*;

    logic       push;
    fbse_cmd_t  push_cmd;
    logic       queue_full;
    logic       head_valid;
    fbse_cmd_t  head;
    logic       pop;
    logic       clearing;

    // front end: registers, clipping, classification into resolved commands;
    // empty or fully clipped spans and unused operations are dropped here
    fbse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .operation  (operation),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .span_start (span_start),
        .span_end   (span_end),
        .queue_full (queue_full),
        .clearing   (clearing),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // command queue
    fbse_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head)
    );

    // back end: frame store, clearing pass, per-byte sequencer, result register
    fbse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .clearing    (clearing),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .pixel_value (pixel_value)
    );

endmodule

@@ tb/tb_nibble_framebuffer_span_engine.sv @@
// Self-checking testbench for the packed 4-bit frame buffer span engine.
module tb_nibble_framebuffer_span_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import fbse_pkg::*;

    // Opcode 7 has no name in the package; the engine must swallow it silently.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // Longest command is a full column. Two queued plus one running.
    localparam int SETTLE_CYCLES = 450;
    localparam int LONG_HOLD     = 400;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 125;
    localparam int CYCLE_LIMIT   = 1_000_000;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the pixel store and the clip/color registers,
    // and keeps the pixel values that pending reads must return.
    // ------------------------------------------------------------------
    class span_engine_scoreboard;
        logic [3:0] pixels [SCREEN_HEIGHT][SCREEN_WIDTH];
        logic [3:0] fg_value;
        logic [3:0] bg_value;
        int         clip_left;
        int         clip_right;
        int         clip_top;
        int         clip_bottom;
        logic [3:0] expected_pixels [$];
        int         errors;

        function new();
            foreach (pixels[y, x])
                pixels[y][x] = 4'd0;
            fg_value    = 4'd15;
            bg_value    = 4'd0;
            clip_left   = 0;
            clip_right  = 127;
            clip_top    = 0;
            clip_bottom = 128;
            errors      = 0;
        endfunction

        function void set_register(logic [PADDR_W-3:0] idx, logic [31:0] value);
            case (idx)
                REG_FG:     fg_value    = value[3:0];
                REG_BG:     bg_value    = value[3:0];
                REG_LEFT:   clip_left   = int'(value[6:0]);
                REG_RIGHT:  clip_right  = int'(value[6:0]);
                REG_TOP:    clip_top    = int'(value[7:0]);
                REG_BOTTOM: clip_bottom = int'(value[7:0]);
                default: ;
            endcase
        endfunction

        function bit on_screen(int x, int y);
            return x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT;
        endfunction

        // x clip and screen bounds are checked per pixel; y clip by the caller
        function void paint(int x, int y, logic [3:0] color, bit invert);
            if (x < clip_left || x > clip_right || !on_screen(x, y))
                return;
            pixels[y][x] = invert ? 4'd15 - pixels[y][x] : color;
        endfunction

        function void hspan(int x0, int x1, int y, logic [3:0] color, bit invert);
            if (y < clip_top || y >= clip_bottom)
                return;
            for (int x = x0; x <= x1; x++)
                paint(x, y, color, invert);
        endfunction

        function void vspan(int y0, int y1, int x, logic [3:0] color, bit invert);
            if (x < clip_left || x > clip_right)
                return;
            if (y0 < clip_top)
                y0 = clip_top;
            for (int y = y0; y <= y1 && y < clip_bottom; y++)
                paint(x, y, color, invert);
        endfunction

        function void note_command(logic [2:0] op, logic signed [8:0] px,
                                   logic signed [8:0] py, logic signed [8:0] s0,
                                   logic signed [8:0] s1);
            int x;
            int y;
            int a;
            int b;
            x = px;
            y = py;
            a = s0;
            b = s1;
            case (op)
                OP_POINT:
                    if (y >= clip_top && y < clip_bottom)
                        paint(x, y, fg_value, 1'b0);
                OP_HFG:  hspan(a, b, y, fg_value, 1'b0);
                OP_HBG:  hspan(a, b, y, bg_value, 1'b0);
                OP_HINV: hspan(a, b, y, 4'd0, 1'b1);
                OP_VFG:  vspan(a, b, x, fg_value, 1'b0);
                OP_VINV: vspan(a, b, x, 4'd0, 1'b1);
                // reads ignore the clip window; off screen reads give zero
                OP_READ: expected_pixels.push_back(on_screen(x, y) ? pixels[y][x] : 4'd0);
                default: ;
            endcase
        endfunction

        function void check_pixel(logic [3:0] actual);
            logic [3:0] want;
            if (expected_pixels.size() == 0)
            begin
                $error("pixel_value: unexpected item, expected none, actual %0d", actual);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            if (actual !== want)
            begin
                $error("pixel_value mismatch: expected %0d, actual %0d", want, actual);
                errors++;
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [PADDR_W-1:0]       paddr;
    logic [PDATA_W-1:0]       pwdata;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;
    logic                     cmd_valid;
    logic                     cmd_stall;
    logic [2:0]               operation;
    logic signed [8:0]        pos_x;
    logic signed [8:0]        pos_y;
    logic signed [8:0]        span_start;
    logic signed [8:0]        span_end;
    logic                     rsp_valid;
    logic                     rsp_stall;
    logic [3:0]               pixel_value;

    span_engine_scoreboard sb = new();

    // Sender gap and receiver stall odds, in percent, per phase
    int gap_pct      = 0;
    int stall_pct    = 0;
    bit hold_request = 1'b0;
    int cycle_count  = 0;

    // Last spot that a drawing command touched; reads aim near it
    int recent_x = 0;
    int recent_y = 0;

    nibble_framebuffer_span_engine u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .operation   (operation),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .span_start  (span_start),
        .span_end    (span_end),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .pixel_value (pixel_value)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: covers the clear after reset plus 1023 commands, the longest a full
    // column, with gaps, stalls and drains, many times over.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Monitor: sampled at the edge, so values are those the DUT saw there.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
                sb.note_command(operation, pos_x, pos_y, span_start, span_end);
            if (rsp_valid && !rsp_stall)
                sb.check_pixel(pixel_value);
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request so the
    // result path backs up into the command queue.
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                rsp_stall <= 1'b0;
                hold_request = 1'b0;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Setup then access phase; psel stays up so writes can run back to back.
    task automatic write_register(input logic [PADDR_W-3:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_register(idx, value);
    endtask

    task automatic load_settings(input int fg, input int bg, input int left, input int right,
                                 input int top, input int bottom);
        write_register(REG_FG, 32'(fg));
        write_register(REG_BG, 32'(bg));
        write_register(REG_LEFT, 32'(left));
        write_register(REG_RIGHT, 32'(right));
        write_register(REG_TOP, 32'(top));
        write_register(REG_BOTTOM, 32'(bottom));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Holds the item until taken; valid stays high for a following item.
    task automatic send_command(input logic [2:0] op, input int px, input int py,
                                input int s0, input int s1);
        cmd_valid  <= 1'b1;
        operation  <= op;
        pos_x      <= 9'(px);
        pos_y      <= 9'(py);
        span_start <= 9'(s0);
        span_end   <= 9'(s1);
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        cmd_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drain all reads, then give the sequencer time to finish queued drawing.
    task automatic settle_engine();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly on screen, some just around the edges, some anywhere in 9 bits.
    function automatic int any_coord();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(0, 127);
        else if (roll < 92)
            return int'($urandom_range(0, 135)) - 4;
        else
            return int'($urandom_range(0, 511)) - 256;
    endfunction

    // Short spans dominate; some cover a whole line, some are empty.
    function automatic int span_tail(input int head);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return head + int'($urandom_range(0, 16));
        else if (roll < 75)
            return head + int'($urandom_range(0, 140));
        else if (roll < 88)
            return any_coord();
        else
            return head - int'($urandom_range(1, 8));
    endfunction

    task automatic send_random_item();
        int         roll;
        logic [2:0] op;
        int         px;
        int         py;
        int         s0;
        int         s1;
        roll = $urandom_range(0, 99);
        if (roll < 35)      op = OP_READ;
        else if (roll < 45) op = OP_HFG;
        else if (roll < 55) op = OP_HBG;
        else if (roll < 63) op = OP_HINV;
        else if (roll < 73) op = OP_VFG;
        else if (roll < 81) op = OP_VINV;
        else if (roll < 99) op = OP_POINT;
        else                op = OP_UNUSED;
        px = any_coord();
        py = any_coord();
        s0 = any_coord();
        s1 = span_tail(s0);
        // Wrap as the 9-bit port will, so the spot tracking below stays honest
        s0 = int'($signed(9'(s0)));
        s1 = int'($signed(9'(s1)));

        case (op)
            OP_READ:
                if ($urandom_range(0, 99) < 65)
                begin
                    px = recent_x + int'($urandom_range(0, 4)) - 2;
                    py = recent_y + int'($urandom_range(0, 4)) - 2;
                end
            OP_HFG, OP_HBG, OP_HINV:
            begin
                recent_x = (s1 >= s0) ? s0 + int'($urandom_range(0, s1 - s0)) : s0;
                recent_y = py;
            end
            OP_VFG, OP_VINV:
            begin
                recent_x = px;
                recent_y = (s1 >= s0) ? s0 + int'($urandom_range(0, s1 - s0)) : s0;
            end
            OP_POINT:
            begin
                recent_x = px;
                recent_y = py;
            end
            default: ;
        endcase

        send_command(op, px, py, s0, s1);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
            pause_sender($urandom_range(1, 12));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int lo;
        int hi;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cmd_valid  = 1'b0;
        operation  = OP_POINT;
        pos_x      = '0;
        pos_y      = '0;
        span_start = '0;
        span_end   = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset colors and full window. The first item waits out
        // the clearing pass behind cmd_stall.
        send_command(OP_READ, 0, 0, 0, 0);            // cleared store reads zero
        send_command(OP_POINT, 0, 0, 0, 0);
        send_command(OP_READ, 0, 0, 0, 0);
        send_command(OP_POINT, 127, 127, 0, 0);       // far corner, odd nibble
        send_command(OP_READ, 127, 127, 0, 0);
        send_command(OP_HFG, 0, 5, -256, 255);        // full-range span clipped to row
        send_command(OP_READ, 127, 5, 0, 0);
        send_command(OP_HBG, 0, 5, 10, 20);
        send_command(OP_READ, 15, 5, 0, 0);
        send_command(OP_HINV, 0, 5, 0, 3);            // 15 becomes 0
        send_command(OP_READ, 1, 5, 0, 0);
        send_command(OP_VFG, 64, 0, -10, 200);
        send_command(OP_READ, 64, 127, 0, 0);
        send_command(OP_VINV, 64, 0, 0, 127);
        send_command(OP_READ, 64, 0, 0, 0);
        send_command(OP_HFG, 0, 6, 10, 9);            // empty span writes nothing
        send_command(OP_READ, 10, 6, 0, 0);
        send_command(OP_READ, -1, 0, 0, 0);           // off-screen reads give zero
        send_command(OP_READ, 128, 5, 0, 0);
        send_command(OP_READ, -256, -256, 0, 0);
        send_command(OP_UNUSED, 3, 3, 0, 10);         // no effect, no result
        send_command(OP_POINT, -1, 3, 0, 0);          // off screen, dropped
        send_command(OP_READ, 255, 255, 0, 0);

        // Random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle_engine();
            case (phase)
                0: load_settings(0, 15, 0, 127, 0, 128);
                1: load_settings($urandom_range(0, 15), $urandom_range(0, 15), 20, 40, 30, 50);
                // inverted window: nothing may be written
                2: load_settings(15, 0, 127, 0, 128, 0);
                // single column, single row
                3: load_settings($urandom_range(0, 15), $urandom_range(0, 15), 127, 127, 0, 1);
                4: load_settings($urandom_range(0, 15), $urandom_range(0, 15), 0, 0, 127, 128);
                7: load_settings($urandom_range(0, 15), $urandom_range(0, 15), 0, 127, 0, 128);
                default:
                begin
                    lo = $urandom_range(0, 127);
                    hi = $urandom_range(0, 128);
                    load_settings($urandom_range(0, 15), $urandom_range(0, 15), lo / 2,
                                  $urandom_range(lo / 2, 127), hi / 3,
                                  $urandom_range(hi / 3, 128));
                end
            endcase

            // Idle odds vary; some phases run flat out, the last one always does
            gap_pct   = (phase == PHASES - 1 || phase % 3 == 2) ? 0 : 12;
            stall_pct = (phase == PHASES - 1 || phase % 3 == 1) ? 0 : 15;
            // Early on, the receiver holds off long enough to back up the queue
            if (phase == 0)
                hold_request = 1'b1;

            repeat (PHASE_ITEMS) send_random_item();
        end

        settle_engine();
        if (sb.pending() != 0)
            $error("pixel_value: %0d reads never answered", sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
